### rtl/nstl_pkg.sv
// ----------------------------------------------------------------------------
// nstl_pkg: shared types and constants for the sine transform line
// Holds the default line length, controller state type, command bundle and
// the integer square root used to build the coefficient scale factors.
// ----------------------------------------------------------------------------
package nstl_pkg;

  localparam int NST_POINTS   = 64;
  localparam int MAX_ADDR_W   = 10;
  localparam int SAMPLE_W     = 24;
  localparam int INDEX_W      = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int DRAIN_W      = 4;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN
  } nstl_state_t;

  // One bundle from the controller to the datapath each cycle.
  typedef struct packed {
    logic                  load_we;
    logic                  load_first;
    logic [MAX_ADDR_W-1:0] load_addr;
    logic                  term_valid;
    logic                  term_first;
    logic                  term_last;
    logic                  term_corr;
    logic                  term_zero;
    logic                  term_odd;
    logic                  fwd;
    logic                  short_frame;
    logic [MAX_ADDR_W-1:0] term_addr;
    logic [MAX_ADDR_W-1:0] out_idx;
  } nstl_cmd_t;

  // Bitwise integer square root, evaluated at elaboration only.
  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned r;
    longint unsigned bt;
    longint unsigned rem;
    int n;
    rem = v;
    r   = 64'd0;
    bt  = 64'd1 << 62;
    for (n = 0; n < 32; n++) begin
      if (rem >= r + bt) begin
        rem = rem - (r + bt);
        r   = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

endpackage

### rtl/nstl_ctrl.sv
// ----------------------------------------------------------------------------
// nstl_ctrl: sequencer for the sine transform line
// Counts samples into the line store, then walks every output through its
// terms plus one correction term, and waits for the datapath to drain.
// ----------------------------------------------------------------------------
module nstl_ctrl #(
  parameter int POINTS = nstl_pkg::NST_POINTS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                last_sample,
  input  logic                cfg_valid,
  input  logic                cfg_direction,
  output logic                cfg_ready,
  output logic                busy,
  output nstl_pkg::nstl_cmd_t cmd
);

  localparam int ADDR_W = $clog2(POINTS);
  localparam int CNT_W  = $clog2(POINTS + 1);

  nstl_pkg::nstl_state_t state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0]  t_r, t_nxt;
  logic              dir_r, dir_nxt;
  logic              line_fwd_r, line_fwd_nxt;
  logic              short_r, short_nxt;
  logic [nstl_pkg::DRAIN_W-1:0] drain_r, drain_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= nstl_pkg::ST_LOAD;
      cnt_r      <= '0;
      i_r        <= '0;
      t_r        <= '0;
      dir_r      <= 1'b0;
      line_fwd_r <= 1'b1;
      short_r    <= 1'b0;
      drain_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      i_r        <= i_nxt;
      t_r        <= t_nxt;
      dir_r      <= dir_nxt;
      line_fwd_r <= line_fwd_nxt;
      short_r    <= short_nxt;
      drain_r    <= drain_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    i_nxt        = i_r;
    t_nxt        = t_r;
    line_fwd_nxt = line_fwd_r;
    short_nxt    = short_r;
    drain_nxt    = drain_r;
    busy         = (state_r != nstl_pkg::ST_LOAD);
    cfg_ready    = (state_r == nstl_pkg::ST_LOAD);
    dir_nxt      = (cfg_valid && cfg_ready) ? cfg_direction : dir_r;

    cmd             = '0;
    cmd.fwd         = line_fwd_r;
    cmd.short_frame = short_r;
    cmd.load_addr   = nstl_pkg::MAX_ADDR_W'(cnt_r[ADDR_W-1:0]);
    cmd.load_first  = (cnt_r == '0);
    cmd.term_addr   = nstl_pkg::MAX_ADDR_W'(t_r[ADDR_W-1:0]);
    cmd.out_idx     = nstl_pkg::MAX_ADDR_W'(i_r);
    cmd.term_odd    = t_r[0];

    unique case (state_r)
      nstl_pkg::ST_LOAD: begin
        if (start) begin
          cmd.load_we = 1'b1;
          cnt_nxt     = cnt_r + 1'b1;
          if (last_sample || cnt_r == CNT_W'(POINTS - 1)) begin
            line_fwd_nxt = !dir_r;
            short_nxt    = (cnt_r != CNT_W'(POINTS - 1));
            i_nxt        = '0;
            t_nxt        = '0;
            state_nxt    = nstl_pkg::ST_RUN;
          end
        end
      end
      nstl_pkg::ST_RUN: begin
        cmd.term_valid = 1'b1;
        cmd.term_first = (t_r == '0);
        cmd.term_last  = (t_r == CNT_W'(POINTS));
        cmd.term_corr  = (t_r == CNT_W'(POINTS));
        // Forward adds the line sum on the final output only; the transpose
        // adds the last sample to every output, which is zero in a short line.
        if (t_r == CNT_W'(POINTS)) begin
          cmd.term_zero = line_fwd_r ? (i_r != ADDR_W'(POINTS - 1)) : short_r;
          t_nxt         = '0;
          i_nxt         = i_r + 1'b1;
          if (i_r == ADDR_W'(POINTS - 1)) begin
            drain_nxt = nstl_pkg::DRAIN_W'(nstl_pkg::DRAIN_CYCLES);
            state_nxt = nstl_pkg::ST_DRAIN;
          end
        end else begin
          cmd.term_zero = (t_r >= cnt_r);
          t_nxt         = t_r + 1'b1;
        end
      end
      nstl_pkg::ST_DRAIN: begin
        drain_nxt = drain_r - 1'b1;
        if (drain_r == '0) begin
          cnt_nxt   = '0;
          state_nxt = nstl_pkg::ST_LOAD;
        end
      end
      default: state_nxt = nstl_pkg::ST_LOAD;
    endcase
  end

endmodule

### rtl/nstl_dp.sv
// ----------------------------------------------------------------------------
// nstl_dp: line store and multiply-accumulate pipeline
// Stores the line, folds the coefficient phase onto a quarter-wave table,
// multiplies, accumulates one output and rounds and saturates it.
// ----------------------------------------------------------------------------
module nstl_dp #(
  parameter int POINTS = nstl_pkg::NST_POINTS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nstl_pkg::nstl_cmd_t                 cmd,
  input  logic signed [nstl_pkg::SAMPLE_W-1:0] sample,
  output logic                                out_strobe,
  output logic signed [nstl_pkg::SAMPLE_W-1:0] out_value,
  output logic [nstl_pkg::INDEX_W-1:0]        out_index,
  output logic                                out_last_result,
  output logic                                out_short_frame,
  output logic                                out_saturated
);

  localparam int SW     = nstl_pkg::SAMPLE_W;
  localparam int ADDR_W = $clog2(POINTS);
  localparam int CNT_W  = $clog2(POINTS + 1);
  localparam int J_W    = $clog2(4 * POINTS) + 1;
  localparam int Q_W    = $clog2(POINTS + 1);
  localparam int OP_W   = SW + ADDR_W;
  localparam int CF_W   = 26;
  localparam int PROD_W = OP_W + CF_W;
  localparam int ACC_W  = PROD_W + CNT_W + 1;
  localparam int RW     = ACC_W - 24;
  localparam int MW     = nstl_pkg::MAX_ADDR_W;

  localparam longint unsigned S2Q = nstl_pkg::isqrt64((64'd1 << 61) / POINTS);
  localparam longint unsigned S1Q = nstl_pkg::isqrt64((64'd1 << 60) / POINTS);
  localparam longint unsigned CORR = (S1Q + S2Q + 64'd32) >> 6;
  localparam logic signed [CF_W-1:0] CORR_C = CF_W'(CORR);
  localparam logic signed [RW-1:0] VMAX = RW'(8388607);
  localparam logic signed [RW-1:0] VMIN = -RW'(8388608);

  // Quarter-wave coefficient table, Q24, built at elaboration.
  logic [24:0] qtab [0:POINTS];
  for (genvar gi = 0; gi <= POINTS; gi++) begin : g_qtab
    localparam longint X  = (longint'(nstl_pkg::PI_Q30) * gi + POINTS) / (2 * POINTS);
    localparam longint X2 = (X * X) >>> 30;
    localparam longint T1 = ((X * X2) >>> 30) / 6;
    localparam longint T2 = ((T1 * X2) >>> 30) / 20;
    localparam longint T3 = ((T2 * X2) >>> 30) / 42;
    localparam longint T4 = ((T3 * X2) >>> 30) / 72;
    localparam longint T5 = ((T4 * X2) >>> 30) / 110;
    localparam longint T6 = ((T5 * X2) >>> 30) / 156;
    localparam longint T7 = ((T6 * X2) >>> 30) / 210;
    localparam longint AC = X - T1 + T2 - T3 + T4 - T5 + T6 - T7;
    localparam longint SV = (AC < 0) ? 64'sd0 :
                            ((AC > (64'sd1 <<< 30)) ? (64'sd1 <<< 30) : AC);
    localparam longint unsigned QV = (S2Q * longint'(SV) + (64'd1 << 35)) >> 36;
    assign qtab[gi] = QV[24:0];
  end

  logic signed [SW-1:0]   mem [0:POINTS-1];
  logic signed [OP_W-1:0] sum_r;
  logic signed [SW-1:0]   vlast_r;

  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      mem[cmd.load_addr[ADDR_W-1:0]] <= sample;
      sum_r <= (cmd.load_first ? '0 : sum_r) + OP_W'(sample);
      if (cmd.load_addr[ADDR_W-1:0] == ADDR_W'(POINTS - 1)) begin
        vlast_r <= sample;
      end
    end
  end

  // Stage 1: memory read and phase index.
  logic [J_W-1:0] j_start, j_step, j_cur;
  logic [J_W:0]   j_sum;
  logic           v1_r, first1_r, last1_r, corr1_r, zero1_r, odd1_r;
  logic [J_W-1:0] j1_r;
  logic [MW-1:0]  idx1_r;
  logic signed [SW-1:0] rd1_r;

  always_comb begin
    j_start = cmd.fwd ? J_W'(cmd.out_idx) + J_W'(1) : J_W'({cmd.out_idx, 1'b0}) + J_W'(1);
    j_step  = cmd.fwd ? J_W'({cmd.out_idx, 1'b0}) + J_W'(2) : j_start;
    j_sum   = (J_W + 1)'(j1_r) + (J_W + 1)'(j_step);
    if (cmd.term_first) begin
      j_cur = j_start;
    end else if (j_sum >= (J_W + 1)'(4 * POINTS)) begin
      j_cur = J_W'(j_sum - (J_W + 1)'(4 * POINTS));
    end else begin
      j_cur = J_W'(j_sum);
    end
  end

  always_ff @(posedge clk) begin
    rd1_r <= mem[cmd.term_addr[ADDR_W-1:0]];
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= cmd.term_valid;
    end
    if (cmd.term_valid) begin
      j1_r <= j_cur;
    end
    first1_r <= cmd.term_first;
    last1_r  <= cmd.term_last;
    corr1_r  <= cmd.term_corr;
    zero1_r  <= cmd.term_zero;
    // The sign flips where the sample position is even (the output index in the transpose).
    odd1_r   <= cmd.fwd ? cmd.term_odd : cmd.out_idx[0];
    idx1_r   <= cmd.out_idx;
  end

  // Stage 2: fold onto the quarter wave and choose the operand.
  logic [Q_W-1:0]         q2_r;
  logic                   neg2_r, v2_r, first2_r, last2_r, corr2_r;
  logic [MW-1:0]          idx2_r;
  logic signed [OP_W-1:0] op2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    priority if (j1_r <= J_W'(POINTS)) begin
      q2_r   <= Q_W'(j1_r);
      neg2_r <= !odd1_r;
    end else if (j1_r <= J_W'(2 * POINTS)) begin
      q2_r   <= Q_W'(J_W'(2 * POINTS) - j1_r);
      neg2_r <= !odd1_r;
    end else if (j1_r <= J_W'(3 * POINTS)) begin
      q2_r   <= Q_W'(j1_r - J_W'(2 * POINTS));
      neg2_r <= odd1_r;
    end else begin
      q2_r   <= Q_W'(J_W'(4 * POINTS) - j1_r);
      neg2_r <= odd1_r;
    end
    if (zero1_r) begin
      op2_r <= '0;
    end else if (corr1_r) begin
      op2_r <= cmd.fwd ? sum_r : OP_W'(vlast_r);
    end else begin
      op2_r <= OP_W'(rd1_r);
    end
    first2_r <= first1_r;
    last2_r  <= last1_r;
    corr2_r  <= corr1_r;
    idx2_r   <= idx1_r;
  end

  // Stage 3: coefficient lookup.
  logic signed [CF_W-1:0] cf3_r;
  logic signed [OP_W-1:0] op3_r;
  logic                   v3_r, first3_r, last3_r;
  logic [MW-1:0]          idx3_r;
  logic signed [CF_W-1:0] mag2;

  assign mag2 = CF_W'(qtab[q2_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    cf3_r    <= corr2_r ? CORR_C : (neg2_r ? -mag2 : mag2);
    op3_r    <= op2_r;
    first3_r <= first2_r;
    last3_r  <= last2_r;
    idx3_r   <= idx2_r;
  end

  // Stage 4: multiply.
  logic signed [PROD_W-1:0] prod4_r;
  logic                     v4_r, first4_r, last4_r;
  logic [MW-1:0]            idx4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    prod4_r  <= PROD_W'(op3_r) * PROD_W'(cf3_r);
    first4_r <= first3_r;
    last4_r  <= last3_r;
    idx4_r   <= idx3_r;
  end

  // Stage 5: accumulate.
  logic signed [ACC_W-1:0] acc_r, acc_nxt, res5_r;
  logic                    v5_r;
  logic [MW-1:0]           idx5_r;

  assign acc_nxt = (first4_r ? '0 : acc_r) + ACC_W'(prod4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r && last4_r;
    end
    if (v4_r) begin
      acc_r <= acc_nxt;
    end
    res5_r <= acc_nxt;
    idx5_r <= idx4_r;
  end

  // Stage 6: round to Q7.16 and saturate.
  logic signed [ACC_W-1:0] rnd;
  logic signed [RW-1:0]    shr;

  assign rnd = res5_r + (ACC_W'(1) <<< 23);
  assign shr = RW'(rnd >>> 24);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= v5_r;
    end
    if (shr > VMAX) begin
      out_value     <= SW'(VMAX);
      out_saturated <= 1'b1;
    end else if (shr < VMIN) begin
      out_value     <= SW'(VMIN);
      out_saturated <= 1'b1;
    end else begin
      out_value     <= SW'(shr);
      out_saturated <= 1'b0;
    end
    out_index       <= idx5_r[nstl_pkg::INDEX_W-1:0];
    out_last_result <= (idx5_r == MW'(POINTS - 1));
    out_short_frame <= cmd.short_frame;
  end

endmodule

### rtl/neumann_sine_transform_line.sv
// ----------------------------------------------------------------------------
// neumann_sine_transform_line: sine transform of one line with correction
// Loads a line of samples, then produces every transformed element by a
// direct sum on one shared multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
// A sample is taken each cycle that start is high and busy is low. The line
// closes on last_sample or on the POINTS-th sample; busy then rises while
// the single multiplier, doing one product per cycle, works through every
// term of every output, and stays high through the drain state. The
// POINTS results appear in index order, one per out_strobe pulse, and
// cannot be held off, so the receiver must take each one as it comes.
// Direction may be written only while busy is low.
module neumann_sine_transform_line #(
  parameter int POINTS = nstl_pkg::NST_POINTS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [nstl_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 in_last_sample,
  output logic                                 out_strobe,
  output logic signed [nstl_pkg::SAMPLE_W-1:0] out_value,
  output logic [nstl_pkg::INDEX_W-1:0]         out_index,
  output logic                                 out_last_result,
  output logic                                 out_short_frame,
  output logic                                 out_saturated,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_direction
);

  nstl_pkg::nstl_cmd_t cmd;

  nstl_ctrl #(.POINTS(POINTS)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .last_sample   (in_last_sample),
    .cfg_valid     (cfg_valid),
    .cfg_direction (cfg_direction),
    .cfg_ready     (cfg_ready),
    .busy          (busy),
    .cmd           (cmd)
  );

  nstl_dp #(.POINTS(POINTS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sample          (in_sample),
    .out_strobe      (out_strobe),
    .out_value       (out_value),
    .out_index       (out_index),
    .out_last_result (out_last_result),
    .out_short_frame (out_short_frame),
    .out_saturated   (out_saturated)
  );

endmodule

### bench/neumann_sine_transform_line_tb.sv
// ----------------------------------------------------------------------------
// Testbench for neumann_sine_transform_line
// Streams lines of Q7.16 samples, short and full, in both directions, and
// checks every transformed element against a bit-exact direct-sum predictor.
// ----------------------------------------------------------------------------
module neumann_sine_transform_line_tb;

  localparam int SAMPLE_W     = nstl_pkg::SAMPLE_W;
  localparam int INDEX_W      = nstl_pkg::INDEX_W;
  localparam int DRAIN_CYCLES = nstl_pkg::DRAIN_CYCLES;
  localparam longint unsigned PI_Q30 = nstl_pkg::PI_Q30;
  localparam int LINE_LEN    = nstl_pkg::NST_POINTS;
  localparam int STALL_LIMIT = 20000;
  localparam logic [SAMPLE_W-1:0] S_MAX = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] S_MIN = 24'h800000;
  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_INV = 1'b1;

  typedef struct {
    logic [SAMPLE_W-1:0] smp;
    logic                last;
  } sample_req_t;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic [INDEX_W-1:0]  idx;
    logic                last;
    logic                shortf;
    logic                sat;
  } element_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic in_last_sample;
  logic out_strobe;
  logic signed [SAMPLE_W-1:0] out_value;
  logic [INDEX_W-1:0] out_index;
  logic out_last_result;
  logic out_short_frame;
  logic out_saturated;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_direction;

  sample_req_t pending_samples[$];
  element_t    expected_elems[$];

  // Predictor state.
  longint      quarter_q24[LINE_LEN+1];
  longint      corr_q24;
  int          line_buf[LINE_LEN];
  int          line_fill;
  longint      line_sum;
  logic        pred_dir;

  int  sender_gap_pct;
  bit  in_taken;
  int  idle_cycles;
  int  errors;
  int  n_samples;
  int  n_lines;
  int  n_elems;
  int  n_sat;

  neumann_sine_transform_line uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample(in_sample), .in_last_sample(in_last_sample),
    .out_strobe(out_strobe), .out_value(out_value), .out_index(out_index),
    .out_last_result(out_last_result), .out_short_frame(out_short_frame),
    .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_direction(cfg_direction)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Quarter-wave sine in Q30 from a Taylor series up to the fifteenth power.
  function automatic longint unsigned quarter_sine(input int i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint acc;
    x = (PI_Q30 * longint'(i) + LINE_LEN) / (2 * LINE_LEN);
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
    return longint'(acc);
  endfunction

  function automatic void build_tables();
    longint unsigned s2q;
    longint unsigned s1q;
    s2q = root64((64'd1 << 61) / LINE_LEN);
    s1q = root64((64'd1 << 60) / LINE_LEN);
    for (int i = 0; i <= LINE_LEN; i++)
      quarter_q24[i] = longint'((s2q * quarter_sine(i) + (64'd1 << 35)) >> 36);
    corr_q24 = longint'((s1q + s2q + 32) >> 6);
  endfunction

  // Signed Q24 weight of sample m in output k, folded onto the quarter wave.
  function automatic longint weight(input int k, input int m);
    int j;
    longint mag;
    bit neg;
    j = ((k + 1) * (2 * m + 1)) % (4 * LINE_LEN);
    neg = 1'b0;
    if (j <= LINE_LEN) mag = quarter_q24[j];
    else if (j <= 2 * LINE_LEN) mag = quarter_q24[2 * LINE_LEN - j];
    else if (j <= 3 * LINE_LEN) begin
      mag = quarter_q24[j - 2 * LINE_LEN];
      neg = 1'b1;
    end else begin
      mag = quarter_q24[4 * LINE_LEN - j];
      neg = 1'b1;
    end
    if (m % 2 == 0) neg = !neg;
    return neg ? -mag : mag;
  endfunction

  // Loads one sample; on line close queues every transformed element.
  function automatic void take_sample(input logic [SAMPLE_W-1:0] smp, input logic last);
    longint padded[LINE_LEN];
    longint acc;
    longint r;
    element_t e;
    bit shortf;
    if (line_fill < LINE_LEN) begin
      line_buf[line_fill] = int'($signed(smp));
      line_fill++;
      line_sum += longint'($signed(smp));
    end
    if (!last && line_fill < LINE_LEN) return;
    shortf = line_fill < LINE_LEN;
    for (int i = 0; i < LINE_LEN; i++) padded[i] = (i < line_fill) ? line_buf[i] : 0;
    for (int i = 0; i < LINE_LEN; i++) begin
      acc = 0;
      if (pred_dir == DIR_FWD) begin
        for (int t = 0; t < LINE_LEN; t++) acc += weight(i, t) * padded[t];
        if (i == LINE_LEN - 1) acc += corr_q24 * line_sum;
      end else begin
        for (int t = 0; t < LINE_LEN; t++) acc += weight(t, i) * padded[t];
        acc += corr_q24 * padded[LINE_LEN - 1];
      end
      r = (acc + (64'sd1 <<< 23)) >>> 24;
      e.sat = 1'b0;
      if (r > 64'sd8388607) begin
        r = 64'sd8388607;
        e.sat = 1'b1;
      end else if (r < -64'sd8388608) begin
        r = -64'sd8388608;
        e.sat = 1'b1;
      end
      e.value = r[SAMPLE_W-1:0];
      e.idx = i[INDEX_W-1:0];
      e.last = (i == LINE_LEN - 1);
      e.shortf = shortf;
      expected_elems.push_back(e);
    end
    line_fill = 0;
    line_sum = 0;
    n_lines++;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s at index %0d: got %0h, expected %0h", what, out_index, got, want);
    errors++;
  endtask

  // Driver: presents the next request once the previous one has been taken.
  always @(negedge clk) begin
    sample_req_t req;
    logic nxt_start;
    if (rst_n) begin
      nxt_start = start;
      if (in_taken || !start) begin
        nxt_start = 1'b0;
        if (pending_samples.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
          req = pending_samples.pop_front();
          in_sample <= req.smp;
          in_last_sample <= req.last;
          nxt_start = 1'b1;
        end
      end
      start <= nxt_start;
    end
  end

  // Monitor: feeds accepted requests to the predictor and checks each element.
  always @(posedge clk) begin
    element_t e;
    if (!rst_n) begin
      in_taken = 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken = start && !busy;
      idle_cycles++;
      if (in_taken || (cfg_valid && cfg_ready)) idle_cycles = 0;
      if (in_taken) begin
        take_sample(in_sample, in_last_sample);
        n_samples++;
      end
      if (out_strobe) begin
        idle_cycles = 0;
        n_elems++;
        if (expected_elems.size() == 0) begin
          report_mismatch("unexpected element", out_value, 0);
        end else begin
          e = expected_elems.pop_front();
          if (out_value !== e.value) report_mismatch("value", out_value, e.value);
          if (out_index !== e.idx) report_mismatch("index", out_index, e.idx);
          if (out_last_result !== e.last) report_mismatch("last_result", out_last_result, e.last);
          if (out_short_frame !== e.shortf)
            report_mismatch("short_frame", out_short_frame, e.shortf);
          if (out_saturated !== e.sat) report_mismatch("saturated", out_saturated, e.sat);
          if (e.sat) n_sat++;
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no request or element moved for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic void queue_line(input int len, input logic [SAMPLE_W-1:0] fill,
                                     input bit use_fill);
    sample_req_t req;
    for (int i = 0; i < len; i++) begin
      req.smp = use_fill ? fill : pick_sample();
      req.last = (i == len - 1) ? ((len < LINE_LEN) ? 1'b1 : 1'($urandom)) : 1'b0;
      pending_samples.push_back(req);
    end
  endfunction

  // Random lines: mostly short, now and then a full one or one of 13 up to LINE_LEN-1 samples.
  function automatic void queue_random(input int budget);
    int count;
    int len;
    count = 0;
    while (count < budget) begin
      case ($urandom_range(19))
        0, 1: len = LINE_LEN;
        2: len = $urandom_range(LINE_LEN - 1, 13);
        default: len = $urandom_range(12, 1);
      endcase
      queue_line(len, '0, 1'b0);
      count += len;
    end
  endfunction

  // The sender holds until the queue drains and every element has come.
  task automatic wait_idle();
    while (pending_samples.size() > 0 || start || expected_elems.size() > 0 || busy)
      @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input logic dir);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_direction <= dir;
    do @(posedge clk); while (!cfg_ready);
    pred_dir = dir;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_sample = '0;
    in_last_sample = 1'b0;
    cfg_valid = 1'b0;
    cfg_direction = 1'b0;
    sender_gap_pct = 0;
    errors = 0;
    n_samples = 0;
    n_lines = 0;
    n_elems = 0;
    n_sat = 0;
    line_fill = 0;
    line_sum = 0;
    pred_dir = DIR_FWD;
    build_tables();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: single-sample extremes, a tiny line, and a full line of the
    // largest value that closes on the count alone and saturates.
    queue_line(1, S_MAX, 1'b1);
    queue_line(1, S_MIN, 1'b1);
    pending_samples.push_back('{smp: 24'hFFFFFF, last: 1'b0});
    pending_samples.push_back('{smp: 24'h000001, last: 1'b1});
    for (int i = 0; i < LINE_LEN; i++) pending_samples.push_back('{smp: S_MAX, last: 1'b0});
    wait_idle();

    write_direction(DIR_INV);
    queue_line(LINE_LEN - 1, S_MIN, 1'b1);
    for (int i = 0; i < LINE_LEN; i++)
      pending_samples.push_back('{smp: S_MIN, last: (i == LINE_LEN - 1)});
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      write_direction((ph % 2 == 0) ? DIR_FWD : DIR_INV);
      case (ph)
        0: sender_gap_pct = 24;
        1: sender_gap_pct = 70;
        default: sender_gap_pct = 0;
      endcase
      queue_random(50);
      wait_idle();
    end

    $display("Covered %0d samples in %0d lines over both directions;", n_samples, n_lines);
    $display("%0d elements checked, %0d of them saturated.", n_elems, n_sat);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/nstl_pkg.sv
rtl/nstl_ctrl.sv
rtl/nstl_dp.sv
rtl/neumann_sine_transform_line.sv
bench/neumann_sine_transform_line_tb.sv
